// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of the priority queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define DPQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define DPQ_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/dpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended priority queue package
// Types, codes and defaults shared by the queue controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dpq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int COUNT_W      = 5;

    localparam logic [1:0] FUNC_INSERT      = 2'd0;
    localparam logic [1:0] FUNC_EXTRACT_MIN = 2'd1;
    localparam logic [1:0] FUNC_EXTRACT_MAX = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] new_priority;
        logic [31:0]        new_payload;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           status;
        logic signed [31:0]   removed_priority;
        logic [31:0]          removed_payload;
        logic signed [31:0]   min_priority;
        logic [31:0]          min_payload;
        logic signed [31:0]   max_priority;
        logic [31:0]          max_payload;
        logic [COUNT_W-1:0]   entry_count;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] prio;
        logic [31:0]        payload;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OP,
        ST_EXT_CAP,
        ST_SCAN,
        ST_PLACE,
        ST_MIN_RD,
        ST_MAX_RD,
        ST_MAX_CAP,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_TAIL,
        RD_PTR_PREV
    } t_rd_sel;

    typedef struct packed {
        logic       load_in;
        t_rd_sel    rd_sel;
        logic       wr_en;
        logic       wr_new;
        logic       wr_at_head;
        logic       set_status;
        logic [1:0] status;
        logic       cap_removed;
        logic       pop_head;
        logic       dec_count;
        logic       inc_count;
        logic       ptr_from_tail;
        logic       ptr_dec;
        logic       cap_min;
        logic       cap_max;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       empty;
        logic       full;
        logic       le;
        logic       ptr_at_head;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/dpq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = dpq_pkg::CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/dpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Priority queue controller
// Sequences insert, extract and result steps over the queue datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module dpq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire dpq_pkg::t_sts i_sts,
    output dpq_pkg::t_cmd      o_cmd
);

    dpq_pkg::t_state r_state;
    dpq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dpq_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = dpq_pkg::ST_OP;
                end
            end
            dpq_pkg::ST_OP: begin
                unique case (i_sts.func) inside
                    dpq_pkg::FUNC_INSERT: begin
                        if (i_sts.full || i_sts.empty) begin
                            n_state = dpq_pkg::ST_MIN_RD;
                        end else begin
                            n_state = dpq_pkg::ST_SCAN;
                        end
                    end
                    dpq_pkg::FUNC_EXTRACT_MIN, dpq_pkg::FUNC_EXTRACT_MAX: begin
                        if (i_sts.empty) begin
                            n_state = dpq_pkg::ST_MIN_RD;
                        end else begin
                            n_state = dpq_pkg::ST_EXT_CAP;
                        end
                    end
                    default: begin
                        n_state = dpq_pkg::ST_MIN_RD;
                    end
                endcase
            end
            dpq_pkg::ST_EXT_CAP: begin
                n_state = dpq_pkg::ST_MIN_RD;
            end
            dpq_pkg::ST_SCAN: begin
                if (i_sts.le) begin
                    n_state = dpq_pkg::ST_MIN_RD;
                end else if (i_sts.ptr_at_head) begin
                    n_state = dpq_pkg::ST_PLACE;
                end
            end
            dpq_pkg::ST_PLACE: begin
                n_state = dpq_pkg::ST_MIN_RD;
            end
            dpq_pkg::ST_MIN_RD: begin
                n_state = dpq_pkg::ST_MAX_RD;
            end
            dpq_pkg::ST_MAX_RD: begin
                n_state = dpq_pkg::ST_MAX_CAP;
            end
            dpq_pkg::ST_MAX_CAP: begin
                n_state = dpq_pkg::ST_OUT;
            end
            dpq_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    n_state = dpq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = dpq_pkg::RD_HEAD;
        o_cmd.status = dpq_pkg::STATUS_OK;
        unique case (r_state)
            dpq_pkg::ST_IDLE: begin
                o_cmd.load_in = i_valid;
            end
            dpq_pkg::ST_OP: begin
                unique case (i_sts.func) inside
                    dpq_pkg::FUNC_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = dpq_pkg::STATUS_FULL;
                        end else if (i_sts.empty) begin
                            o_cmd.wr_en      = 1'b1;
                            o_cmd.wr_new     = 1'b1;
                            o_cmd.wr_at_head = 1'b1;
                            o_cmd.inc_count  = 1'b1;
                        end else begin
                            o_cmd.rd_sel        = dpq_pkg::RD_TAIL;
                            o_cmd.ptr_from_tail = 1'b1;
                        end
                    end
                    dpq_pkg::FUNC_EXTRACT_MIN, dpq_pkg::FUNC_EXTRACT_MAX: begin
                        if (i_sts.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = dpq_pkg::STATUS_EMPTY;
                        end else if (i_sts.func == dpq_pkg::FUNC_EXTRACT_MAX) begin
                            o_cmd.rd_sel = dpq_pkg::RD_TAIL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            dpq_pkg::ST_EXT_CAP: begin
                o_cmd.cap_removed = 1'b1;
                o_cmd.dec_count   = 1'b1;
                o_cmd.pop_head    = (i_sts.func == dpq_pkg::FUNC_EXTRACT_MIN);
            end
            dpq_pkg::ST_SCAN: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.le) begin
                    o_cmd.wr_new    = 1'b1;
                    o_cmd.inc_count = 1'b1;
                end else if (!i_sts.ptr_at_head) begin
                    o_cmd.rd_sel  = dpq_pkg::RD_PTR_PREV;
                    o_cmd.ptr_dec = 1'b1;
                end
            end
            dpq_pkg::ST_PLACE: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.wr_new     = 1'b1;
                o_cmd.wr_at_head = 1'b1;
                o_cmd.inc_count  = 1'b1;
            end
            dpq_pkg::ST_MIN_RD: begin
                o_cmd.rd_sel = dpq_pkg::RD_HEAD;
            end
            dpq_pkg::ST_MAX_RD: begin
                o_cmd.cap_min = 1'b1;
                o_cmd.rd_sel  = dpq_pkg::RD_TAIL;
            end
            dpq_pkg::ST_MAX_CAP: begin
                o_cmd.cap_max = 1'b1;
            end
            dpq_pkg::ST_OUT: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

    assign o_stall = (r_state != dpq_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/dpq_datapath.sv =====
// ----------------------------------------------------------------------------
// Priority queue datapath
// Circular sorted entry store with head, count, scan pointer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpq_datapath #(
    parameter int CAPACITY = dpq_pkg::CAPACITY_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dpq_pkg::t_in_item   i_item,
    input  wire dpq_pkg::t_cmd       i_cmd,
    output dpq_pkg::t_sts            o_sts,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output dpq_pkg::t_out_item       o_item
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [1:0]          r_func;
    dpq_pkg::t_entry     r_new;
    logic [1:0]          r_status;
    dpq_pkg::t_entry     r_removed;
    dpq_pkg::t_entry     r_min;
    dpq_pkg::t_entry     r_max;
    logic [IW-1:0]       r_head;
    logic [IW-1:0]       r_ptr;
    logic [CW-1:0]       r_count;
    dpq_pkg::t_out_item  r_out;
    logic                r_out_valid;

    logic [IW:0]           w_tail_sum;
    logic [IW-1:0]         w_tail;
    logic [IW-1:0]         w_rd_addr;
    logic [IW-1:0]         w_wr_addr;
    dpq_pkg::t_entry       w_wr_data;
    logic [$bits(dpq_pkg::t_entry)-1:0] w_rd_raw;
    dpq_pkg::t_entry       w_rd_entry;
    logic                  w_empty;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
        return (p == IW'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] p);
        return (p == '0) ? IW'(CAPACITY - 1) : p - 1'b1;
    endfunction

    assign w_empty    = (r_count == '0);
    assign w_tail_sum = {1'b0, r_head} + {1'b0, IW'(r_count - 1'b1)};
    assign w_tail     = (w_tail_sum >= (IW + 1)'(CAPACITY))
                      ? IW'(w_tail_sum - (IW + 1)'(CAPACITY)) : w_tail_sum[IW-1:0];

    always_comb begin
        unique case (i_cmd.rd_sel)
            dpq_pkg::RD_HEAD:     w_rd_addr = r_head;
            dpq_pkg::RD_TAIL:     w_rd_addr = w_tail;
            dpq_pkg::RD_PTR_PREV: w_rd_addr = wrap_dec(r_ptr);
            default:              w_rd_addr = r_head;
        endcase
    end

    assign w_wr_addr  = i_cmd.wr_at_head ? r_head : wrap_inc(r_ptr);
    assign w_wr_data  = i_cmd.wr_new ? r_new : w_rd_entry;
    assign w_rd_entry = dpq_pkg::t_entry'(w_rd_raw);

    dpq_ram #(
        .WIDTH ($bits(dpq_pkg::t_entry)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.pop_head) begin
                r_head <= wrap_inc(r_head);
            end
            if (i_cmd.inc_count) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func        <= i_item.func;
            r_new.prio    <= i_item.new_priority;
            r_new.payload <= i_item.new_payload;
            r_status      <= dpq_pkg::STATUS_OK;
            r_removed     <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status;
            end
            if (i_cmd.cap_removed) begin
                r_removed <= w_rd_entry;
            end
        end
        if (i_cmd.ptr_from_tail) begin
            r_ptr <= w_tail;
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= wrap_dec(r_ptr);
        end
        if (i_cmd.cap_min) begin
            r_min <= w_rd_entry;
        end
        if (i_cmd.cap_max) begin
            r_max <= w_rd_entry;
        end
        if (i_cmd.load_out) begin
            r_out.status           <= r_status;
            r_out.removed_priority <= r_removed.prio;
            r_out.removed_payload  <= r_removed.payload;
            r_out.min_priority     <= w_empty ? '0 : r_min.prio;
            r_out.min_payload      <= w_empty ? '0 : r_min.payload;
            r_out.max_priority     <= w_empty ? '0 : r_max.prio;
            r_out.max_payload      <= w_empty ? '0 : r_max.payload;
            r_out.entry_count      <= dpq_pkg::COUNT_W'(r_count);
        end
    end

    assign o_sts.func        = r_func;
    assign o_sts.empty       = w_empty;
    assign o_sts.full        = (r_count == CW'(CAPACITY));
    assign o_sts.le          = (w_rd_entry.prio <= r_new.prio);
    assign o_sts.ptr_at_head = (r_ptr == r_head);
    assign o_sts.out_free    = !r_out_valid || !i_stall;

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

// ===== rtl/double_ended_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Double-ended priority queue
// Bounded queue of priority and payload pairs with insert, extract-minimum
// and extract-maximum, each answered by one result transfer.
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY entries in one RAM, kept in ascending priority
// order as a circular list, so an extract-minimum only advances the head and an
// extract-maximum only shortens the list. An insert goes after all entries of
// equal priority and shifts the entries of higher priority up by one slot, one
// entry per cycle through the single RAM write and read ports. One item is in
// work at a time: a new input transfer is taken only once the result of the
// last one is loaded, and an insert into a queue that is neither empty nor
// full first scans from the tail past every stored entry of higher priority.
// The states MIN_RD, MAX_RD and MAX_CAP that come before OUT read the minimum
// and maximum back from the RAM. No clearing pass is needed after reset. The
// entry count of a result is given modulo 32.
`default_nettype none

`include "assert_macros.svh"

module double_ended_priority_queue #(
    parameter int CAPACITY = dpq_pkg::CAPACITY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire dpq_pkg::t_in_item  i_item,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output dpq_pkg::t_out_item      o_item
);

    dpq_pkg::t_cmd w_cmd;
    dpq_pkg::t_sts w_sts;

    dpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    dpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    `DPQ_ASSERT(a_busy_after_accept, i_valid && !o_stall |=> o_stall, "queue idle after input transfer")
    `DPQ_ASSERT(a_load_needs_slot, w_cmd.load_out |-> w_sts.out_free, "result loaded over a pending one")
    `DPQ_ASSERT(a_empty_zero, w_cmd.load_out && w_sts.empty |=> o_item.min_priority == 0 && o_item.max_priority == 0, "empty queue reports nonzero bounds")
    `DPQ_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

`default_nettype wire

// ===== tb/double_ended_priority_queue_checker.sv =====
// ----------------------------------------------------------------------------
// Double-ended priority queue checker
// Watches the input and result channels of the queue, keeps its own sorted
// copy of the stored entries, works out the result of every accepted input
// transfer and compares each accepted result transfer field by field.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_checker
    import dpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_error_count,
    output int        o_pending,
    output int        o_full_rejects,
    output int        o_empty_rejects
);

    t_entry    stored[CAPACITY];
    int        stored_total = 0;
    t_out_item pending_reports[$];
    int        errors = 0;
    int        results_seen = 0;
    int        full_rejects = 0;
    int        empty_rejects = 0;

    initial begin
        o_error_count   = 0;
        o_pending       = 0;
        o_full_rejects  = 0;
        o_empty_rejects = 0;
    end

    function automatic t_out_item next_queue_report(t_in_item item);
        t_out_item rep;
        int        pos;
        int        k;
        rep = '0;
        rep.status = STATUS_OK;
        case (item.func)
            FUNC_INSERT: begin
                if (stored_total >= CAPACITY) begin
                    rep.status = STATUS_FULL;
                    full_rejects++;
                end else begin
                    pos = 0;
                    while (pos < stored_total && stored[pos].prio <= item.new_priority)
                        pos++;
                    for (k = stored_total; k > pos; k--)
                        stored[k] = stored[k - 1];
                    stored[pos].prio    = item.new_priority;
                    stored[pos].payload = item.new_payload;
                    stored_total++;
                end
            end
            FUNC_EXTRACT_MIN: begin
                if (stored_total == 0) begin
                    rep.status = STATUS_EMPTY;
                    empty_rejects++;
                end else begin
                    rep.removed_priority = stored[0].prio;
                    rep.removed_payload  = stored[0].payload;
                    for (k = 0; k + 1 < stored_total; k++)
                        stored[k] = stored[k + 1];
                    stored_total--;
                end
            end
            FUNC_EXTRACT_MAX: begin
                if (stored_total == 0) begin
                    rep.status = STATUS_EMPTY;
                    empty_rejects++;
                end else begin
                    rep.removed_priority = stored[stored_total - 1].prio;
                    rep.removed_payload  = stored[stored_total - 1].payload;
                    stored_total--;
                end
            end
            default: begin
            end
        endcase
        if (stored_total > 0) begin
            rep.min_priority = stored[0].prio;
            rep.min_payload  = stored[0].payload;
            rep.max_priority = stored[stored_total - 1].prio;
            rep.max_payload  = stored[stored_total - 1].payload;
        end
        rep.entry_count = COUNT_W'(stored_total);
        return rep;
    endfunction

    task automatic log_mismatch(string msg);
        errors++;
        if (errors <= 100)
            $display("MISMATCH result %0d: %s", results_seen, msg);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            stored_total = 0;
            pending_reports.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                pending_reports.push_back(next_queue_report(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (pending_reports.size() == 0) begin
                    log_mismatch("result transfer with no result expected");
                end else begin
                    want = pending_reports.pop_front();
                    compare_field("status", i_out_item.status, want.status);
                    compare_field("removed_priority", i_out_item.removed_priority,
                                  want.removed_priority);
                    compare_field("removed_payload", i_out_item.removed_payload,
                                  want.removed_payload);
                    compare_field("min_priority", i_out_item.min_priority,
                                  want.min_priority);
                    compare_field("min_payload", i_out_item.min_payload, want.min_payload);
                    compare_field("max_priority", i_out_item.max_priority,
                                  want.max_priority);
                    compare_field("max_payload", i_out_item.max_payload, want.max_payload);
                    compare_field("entry_count", i_out_item.entry_count, want.entry_count);
                end
            end
        end
        o_error_count   <= errors;
        o_pending       <= pending_reports.size();
        o_full_rejects  <= full_rejects;
        o_empty_rejects <= empty_rejects;
    end

endmodule

// ===== tb/double_ended_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// Double-ended priority queue testbench
// Drives directed and random insert, extract and unused-code transfers with
// random gaps and result stalls, lets the checker predict and compare every
// result, and gives the verdict once all results have arrived.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_tb;
    import dpq_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int ITEM_TOTAL  = 1650;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 40;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_item  i_item = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_item;

    int error_count;
    int pending_count;
    int full_rejects;
    int empty_rejects;
    int sent_by_func[4] = '{0, 0, 0, 0};
    int idle_cycles = 0;
    int cycle_count = 0;
    int stall_left = 0;

    double_ended_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    double_ended_priority_queue_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_in_item       (i_item),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out_item      (o_item),
        .o_error_count   (error_count),
        .o_pending       (pending_count),
        .o_full_rejects  (full_rejects),
        .o_empty_rejects (empty_rejects)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The result side runs without new stalls for part of each counter period.
    always @(posedge i_clk) begin : result_stall
        int r;
        cycle_count <= cycle_count + 1;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (cycle_count % 1024 < 200) begin
            i_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            i_stall <= (r >= 60);
            stall_left <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic logic signed [31:0] pick_priority();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return int'($urandom_range(0, 15)) - 8;
        else if (r < 80)
            return $urandom;
        else if (r < 92) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0;
                default: return -32'sd1;
            endcase
        end else if ($urandom_range(0, 1) == 0)
            return 32'sh8000_0000 + $urandom_range(0, 3);
        else
            return 32'sh7FFF_FFFF - $urandom_range(0, 3);
    endfunction

    function automatic logic [1:0] pick_func(int insert_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return FUNC_UNUSED;
        else if (r < 3 + insert_pct * 97 / 100)
            return FUNC_INSERT;
        else
            return ($urandom_range(0, 1) == 0) ? FUNC_EXTRACT_MIN : FUNC_EXTRACT_MAX;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic send_op(logic [1:0] func, logic signed [31:0] prio,
                           logic [31:0] payload, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item.func <= func;
        i_item.new_priority <= prio;
        i_item.new_payload <= payload;
        sent_by_func[func]++;
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin : stimulus
        int  n;
        int  insert_pct;
        bit  calm;
        insert_pct = 50;
        calm = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(FUNC_EXTRACT_MIN, 32'sh0, 32'h0, 0);
        send_op(FUNC_EXTRACT_MAX, 32'sh0, 32'h0, 0);
        send_op(FUNC_UNUSED, -32'sd1, 32'hFFFF_FFFF, 0);
        send_op(FUNC_INSERT, 32'sd123, 32'hDEAD_BEEF, 0);
        send_op(FUNC_EXTRACT_MAX, 32'sh0, 32'h0, 0);
        send_op(FUNC_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 0);
        send_op(FUNC_INSERT, 32'sh8000_0000, 32'h0, 0);
        send_op(FUNC_INSERT, 32'sh0, 32'hAAAA_5555, 0);
        send_op(FUNC_INSERT, 32'sh0, 32'h5555_AAAA, 0);
        send_op(FUNC_INSERT, -32'sd1, 32'h1, 0);
        for (n = 0; n < 11; n++)
            send_op(FUNC_INSERT, n % 4 - 1, 32'h100 + n, pick_gap());
        send_op(FUNC_INSERT, 32'sd5, 32'h1234_5678, 0);
        send_op(FUNC_UNUSED, 32'sh0, 32'h0, 0);
        send_op(FUNC_EXTRACT_MIN, 32'sh0, 32'h0, 0);
        send_op(FUNC_EXTRACT_MAX, 32'sh0, 32'h0, 0);

        for (n = 0; n < ITEM_TOTAL - 25; n++) begin
            if (n % 60 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 80;
                    1: insert_pct = 25;
                    default: insert_pct = 50;
                endcase
                calm = ($urandom_range(0, 3) == 0);
            end
            if (n % 250 == 125) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending_count != 0);
            end
            send_op(pick_func(insert_pct), pick_priority(), $urandom, calm ? 0 : pick_gap());
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending_count != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d inserts, %0d extract-min, %0d extract-max, %0d unused-code transfers.",
                 sent_by_func[FUNC_INSERT], sent_by_func[FUNC_EXTRACT_MIN],
                 sent_by_func[FUNC_EXTRACT_MAX], sent_by_func[FUNC_UNUSED]);
        $display("Inserts refused on a full queue: %0d, extracts refused on an empty queue: %0d.",
                 full_rejects, empty_rejects);
        if (error_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
